[design/dttd_pkg.sv]
// ----------------------------------------------------------------------------
// dttd_pkg: shared types and constants of the decimal text to double block
// Character codes, double precision constants, state and operation codes.
// ----------------------------------------------------------------------------
package dttd_pkg;

  localparam int MAX_DIGITS_DEF   = 18;
  localparam int MAX_EXPONENT_DEF = 400;
  localparam int ACC_W            = 60;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [63:0] DBL_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_TEN = 64'h4024_0000_0000_0000;
  localparam logic [63:0] DBL_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] EXP_MAX = 11'h7FF;

  typedef enum logic [1:0] {
    MODE_WHOLE = 2'd0,
    MODE_FRAC  = 2'd1,
    MODE_EXP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_CVT = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_ADD = 2'd3
  } fpu_op_e;

  typedef struct packed {
    logic    start;
    fpu_op_e op;
  } fpu_req_t;

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_MNORM, F_DIV, F_ALIGN, F_ADDS, F_CVT, F_DENORM, F_ROUND
  } fpu_state_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CVTW, S_WCVTW, S_CVTF, S_WCVTF, S_POWF, S_WPOWF, S_DIVF, S_WDIVF,
    S_ADD, S_WADD, S_POWE, S_WPOWE, S_SCALE, S_WSCALE, S_OUT
  } seq_state_e;

  // Largest whole part that still fits in n decimal digits.
  function automatic logic [63:0] pow10_minus1(input int n);
    logic [63:0] l;
    l = 64'd1;
    for (int i = 0; i < n; i++) begin
      l = l * 64'd10;
    end
    return l - 64'd1;
  endfunction

endpackage

[design/dttd_scan.sv]
// ----------------------------------------------------------------------------
// dttd_scan: character scanner
// Tracks whole part, fraction and exponent digits and their sign characters.
// ----------------------------------------------------------------------------
module dttd_scan #(
  parameter int MAX_DIGITS   = dttd_pkg::MAX_DIGITS_DEF,
  parameter int MAX_EXPONENT = dttd_pkg::MAX_EXPONENT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 take_i,
  input  logic [7:0]                           char_i,
  input  logic                                 clear_i,
  output logic                                 mant_neg_o,
  output logic [dttd_pkg::ACC_W-1:0]           whole_o,
  output logic [dttd_pkg::ACC_W-1:0]           frac_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]      flen_o,
  output logic [$clog2(MAX_EXPONENT+1)-1:0]    exp_o,
  output logic                                 exp_neg_o,
  output logic                                 ovf_o
);
  import dttd_pkg::*;

  localparam int FLEN_W = $clog2(MAX_DIGITS + 1);
  localparam int EXP_W  = $clog2(MAX_EXPONENT + 1);
  localparam int EW2    = EXP_W + 4;
  localparam logic [63:0] WHOLE_LIMIT = pow10_minus1(MAX_DIGITS);

  mode_e              mode_q, mode_d;
  logic               mneg_q, mneg_d, eneg_q, eneg_d, ovf_q, ovf_d;
  logic [ACC_W-1:0]   whole_q, whole_d, frac_q, frac_d;
  logic [FLEN_W-1:0]  flen_q, flen_d;
  logic [EXP_W-1:0]   exp_q, exp_d;

  logic               is_digit;
  logic [3:0]         dig;
  logic [63:0]        w_ext, w_new;
  logic [ACC_W-1:0]   f_new;
  logic [EW2-1:0]     e_ext, e_new;

  always_comb begin
    is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    dig      = is_digit ? 4'(char_i - CH_ZERO) : 4'd0;
    w_ext    = {4'd0, whole_q};
    w_new    = (w_ext << 3) + (w_ext << 1) + 64'(dig);
    f_new    = (frac_q << 3) + (frac_q << 1) + ACC_W'(dig);
    e_ext    = EW2'(exp_q);
    e_new    = (e_ext << 3) + (e_ext << 1) + EW2'(dig);

    mode_d  = mode_q;
    mneg_d  = mneg_q;
    eneg_d  = eneg_q;
    ovf_d   = ovf_q;
    whole_d = whole_q;
    frac_d  = frac_q;
    flen_d  = flen_q;
    exp_d   = exp_q;

    if (clear_i) begin
      mode_d  = MODE_WHOLE;
      mneg_d  = 1'b0;
      eneg_d  = 1'b0;
      ovf_d   = 1'b0;
      whole_d = '0;
      frac_d  = '0;
      flen_d  = '0;
      exp_d   = '0;
    end else if (take_i && (char_i != 8'd0)) begin
      case (mode_q)
        MODE_FRAC: begin
          if (is_digit) begin
            if (32'(flen_q) >= MAX_DIGITS) begin
              ovf_d = 1'b1;
            end else begin
              frac_d = f_new;
              flen_d = flen_q + 1'b1;
            end
          end
          if (char_i == CH_LOW_E || char_i == CH_UP_E) mode_d = MODE_EXP;
        end
        MODE_EXP: begin
          if (char_i == CH_MINUS) eneg_d = 1'b1;
          if (is_digit) begin
            if (32'(e_new) > MAX_EXPONENT) begin
              exp_d = EXP_W'(MAX_EXPONENT);
              ovf_d = 1'b1;
            end else begin
              exp_d = e_new[EXP_W-1:0];
            end
          end
        end
        default: begin
          if (char_i == CH_MINUS) mneg_d = 1'b1;
          if (is_digit) begin
            if (w_new > WHOLE_LIMIT) ovf_d = 1'b1;
            else whole_d = w_new[ACC_W-1:0];
          end
          if (char_i == CH_DOT) mode_d = MODE_FRAC;
          if (char_i == CH_LOW_E || char_i == CH_UP_E) mode_d = MODE_EXP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_WHOLE;
      mneg_q  <= 1'b0;
      eneg_q  <= 1'b0;
      ovf_q   <= 1'b0;
      whole_q <= '0;
      frac_q  <= '0;
      flen_q  <= '0;
      exp_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      mneg_q  <= mneg_d;
      eneg_q  <= eneg_d;
      ovf_q   <= ovf_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      flen_q  <= flen_d;
      exp_q   <= exp_d;
    end
  end

  assign mant_neg_o = mneg_q;
  assign whole_o    = whole_q;
  assign frac_o     = frac_q;
  assign flen_o     = flen_q;
  assign exp_o      = exp_q;
  assign exp_neg_o  = eneg_q;
  assign ovf_o      = ovf_q;

endmodule

[design/dttd_fpu.sv]
// ----------------------------------------------------------------------------
// dttd_fpu: shared double precision unit
// Integer convert, multiply, divide and add of non-negative operands, each
// one bit per cycle, followed by a common denormalize and round stage.
// ----------------------------------------------------------------------------
module dttd_fpu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dttd_pkg::fpu_req_t req_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output logic               done_o,
  output logic [63:0]        res_o
);
  import dttd_pkg::*;

  localparam logic signed [13:0] BIAS_S = 14'sd1023;

  fpu_state_e         state_q, state_d;
  logic               done_q, done_d;
  logic [63:0]        res_q, res_d;
  logic               s_q, s_d, st_q, st_d;
  logic signed [13:0] e_q, e_d;
  logic [55:0]        m_q, m_d;
  logic [105:0]       acc_q, acc_d;
  logic [52:0]        ma_q, ma_d, mb_q, mb_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [11:0]        dd_q, dd_d;

  logic [10:0]        ea, eb;
  logic [52:0]        siga, sigb;
  logic               a_zero, b_zero, a_inf, b_inf, s_ab;
  logic signed [13:0] ea_s, eb_s;
  logic [53:0]        sum54, mant54;
  logic [54:0]        rem, rem2;
  logic               ge, inc;
  logic [56:0]        sum57;
  logic [52:0]        mant53;
  logic signed [13:0] en;

  always_comb begin
    ea     = a_i[62:52];
    eb     = b_i[62:52];
    siga   = {|ea, a_i[51:0]};
    sigb   = {|eb, b_i[51:0]};
    a_zero = ~|a_i[62:0];
    b_zero = ~|b_i[62:0];
    a_inf  = (ea == EXP_MAX);
    b_inf  = (eb == EXP_MAX);
    s_ab   = a_i[63] ^ b_i[63];
    ea_s   = $signed({3'd0, ea});
    eb_s   = $signed({3'd0, eb});

    sum54  = {1'b0, acc_q[105:53]} + (mb_q[0] ? {1'b0, ma_q} : 54'd0);
    rem    = acc_q[54:0];
    ge     = rem >= {2'd0, mb_q};
    rem2   = ge ? rem - {2'd0, mb_q} : rem;
    sum57  = {1'b0, m_q} + {1'b0, acc_q[55:0]};
    inc    = m_q[2] & (m_q[3] | m_q[1] | m_q[0] | st_q);
    mant54 = {1'b0, m_q[55:3]} + 54'(inc);
    if (mant54[53]) begin
      mant53 = mant54[53:1];
      en     = e_q + 14'sd1;
    end else begin
      mant53 = mant54[52:0];
      en     = e_q;
    end

    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    s_d     = s_q;
    st_d    = st_q;
    e_d     = e_q;
    m_d     = m_q;
    acc_d   = acc_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    cnt_d   = cnt_q;
    dd_d    = dd_q;

    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          st_d = 1'b0;
          case (req_i.op)
            OP_CVT: begin
              if (a_i[59:0] == 60'd0) begin
                res_d  = 64'd0;
                done_d = 1'b1;
              end else begin
                acc_d   = {46'd0, a_i[59:0]};
                e_d     = BIAS_S + 14'sd63;
                s_d     = 1'b0;
                state_d = F_CVT;
              end
            end
            OP_MUL: begin
              if (a_inf || b_inf) begin
                // Zero times infinity gives the default quiet NaN.
                res_d  = (a_zero || b_zero) ? DBL_NAN : {s_ab, EXP_MAX, 52'd0};
                done_d = 1'b1;
              end else if (a_zero || b_zero) begin
                res_d  = {s_ab, 63'd0};
                done_d = 1'b1;
              end else begin
                acc_d   = '0;
                ma_d    = siga;
                mb_d    = sigb;
                s_d     = s_ab;
                e_d     = ea_s + eb_s - BIAS_S;
                cnt_d   = 6'd53;
                state_d = F_MUL;
              end
            end
            OP_DIV: begin
              if (b_inf || a_zero) begin
                res_d  = {s_ab, 63'd0};
                done_d = 1'b1;
              end else begin
                mb_d = sigb;
                s_d  = s_ab;
                m_d  = '0;
                if (siga < sigb) begin
                  acc_d = {52'd0, siga, 1'b0};
                  e_d   = ea_s - eb_s + BIAS_S - 14'sd1;
                end else begin
                  acc_d = {53'd0, siga};
                  e_d   = ea_s - eb_s + BIAS_S;
                end
                cnt_d   = 6'd56;
                state_d = F_DIV;
              end
            end
            default: begin
              s_d = a_i[63];
              if (ea >= eb) begin
                m_d   = {siga, 3'd0};
                acc_d = {50'd0, sigb, 3'd0};
                dd_d  = {1'b0, ea} - {1'b0, eb};
                e_d   = ea_s;
              end else begin
                m_d   = {sigb, 3'd0};
                acc_d = {50'd0, siga, 3'd0};
                dd_d  = {1'b0, eb} - {1'b0, ea};
                e_d   = eb_s;
              end
              state_d = F_ALIGN;
            end
          endcase
        end
      end
      F_MUL: begin
        acc_d = {sum54, acc_q[52:1]};
        mb_d  = mb_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = F_MNORM;
      end
      F_MNORM: begin
        if (acc_q[105]) begin
          m_d  = acc_q[105:50];
          st_d = |acc_q[49:0];
          e_d  = e_q + 14'sd1;
        end else begin
          m_d  = acc_q[104:49];
          st_d = |acc_q[48:0];
        end
        state_d = F_DENORM;
      end
      F_DIV: begin
        m_d   = {m_q[54:0], ge};
        acc_d = {51'd0, rem2[53:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          st_d    = (rem2 != 55'd0);
          state_d = F_DENORM;
        end
      end
      F_ALIGN: begin
        if (dd_q == 12'd0) begin
          state_d = F_ADDS;
        end else if (dd_q > 12'd57) begin
          st_d  = st_q | (|acc_q[55:0]);
          acc_d = '0;
          dd_d  = 12'd0;
        end else begin
          acc_d = acc_q >> 1;
          st_d  = st_q | acc_q[0];
          dd_d  = dd_q - 12'd1;
        end
      end
      F_ADDS: begin
        if (sum57[56]) begin
          m_d  = sum57[56:1];
          st_d = st_q | sum57[0];
          e_d  = e_q + 14'sd1;
        end else begin
          m_d  = sum57[55:0];
        end
        state_d = F_DENORM;
      end
      F_CVT: begin
        if (acc_q[63]) begin
          m_d     = acc_q[63:8];
          st_d    = |acc_q[7:0];
          state_d = F_DENORM;
        end else begin
          acc_d = acc_q << 1;
          e_d   = e_q - 14'sd1;
        end
      end
      F_DENORM: begin
        // Below the normal range the significand moves right one bit a cycle, or is flushed at once below -58.
        if (e_q < 14'sd1) begin
          if (e_q < -14'sd58) begin
            st_d = st_q | (|m_q);
            m_d  = '0;
            e_d  = 14'sd1;
          end else begin
            m_d  = m_q >> 1;
            st_d = st_q | m_q[0];
            e_d  = e_q + 14'sd1;
          end
        end else begin
          state_d = F_ROUND;
        end
      end
      F_ROUND: begin
        if (en >= 14'sd2047) begin
          res_d = {s_q, EXP_MAX, 52'd0};
        end else begin
          res_d = {s_q, (mant53[52] ? en[10:0] : 11'd0), mant53[51:0]};
        end
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    s_q   <= s_d;
    st_q  <= st_d;
    e_q   <= e_d;
    m_q   <= m_d;
    acc_q <= acc_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    cnt_q <= cnt_d;
    dd_q  <= dd_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[design/decimal_text_to_double.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_double: character-serial decimal number parser
//
//   channel | direction | payload
//   s_axis  | in        | tdata[7:0] char_code, tlast last_char
//   m_axis  | out       | tdata[63:0] value_bits, tuser digit_overflow
//
// A character that is not last is taken while the block is idle. After the
// last character the shared floating-point unit runs two integer converts,
// the fraction divide, the add, one multiply per power of ten (fraction
// digits plus exponent, stopping once infinite) and the final scale, a
// multiply, or a divide for a negative exponent.
// Reset is asynchronous and clears the scanner and both sequencers.
// The result waits in an output register; a stalled output only holds the
// block once the next number's result is ready.
// ----------------------------------------------------------------------------
module decimal_text_to_double #(
  parameter int MAX_DIGITS   = dttd_pkg::MAX_DIGITS_DEF,
  parameter int MAX_EXPONENT = dttd_pkg::MAX_EXPONENT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value_bits
  output logic        m_axis_tuser    // [0] digit_overflow
);
  import dttd_pkg::*;

  localparam int FLEN_W = $clog2(MAX_DIGITS + 1);
  localparam int EXP_W  = $clog2(MAX_EXPONENT + 1);
  localparam int K_W    = (FLEN_W > EXP_W) ? FLEN_W : EXP_W;

  seq_state_e        state_q, state_d;
  logic [63:0]       r0_q, r0_d, r1_q, r1_d, pw_q, pw_d;
  logic [K_W-1:0]    k_q, k_d;
  logic              ovalid_q, ovalid_d, ouser_q, ouser_d;
  logic [63:0]       odata_q, odata_d;

  logic              take, clear, mneg, eneg, ovf;
  logic [ACC_W-1:0]  whole, frac;
  logic [FLEN_W-1:0] flen;
  logic [EXP_W-1:0]  expo;

  fpu_req_t          req;
  logic [63:0]       fa, fb, fres;
  logic              fdone, pw_inf, r0_nan;

  assign s_axis_tready = (state_q == S_IDLE);
  assign take          = s_axis_tvalid && s_axis_tready;

  dttd_scan #(
    .MAX_DIGITS   (MAX_DIGITS),
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .char_i     (s_axis_tdata),
    .clear_i    (clear),
    .mant_neg_o (mneg),
    .whole_o    (whole),
    .frac_o     (frac),
    .flen_o     (flen),
    .exp_o      (expo),
    .exp_neg_o  (eneg),
    .ovf_o      (ovf)
  );

  dttd_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (fa),
    .b_i    (fb),
    .done_o (fdone),
    .res_o  (fres)
  );

  always_comb begin
    pw_inf = (pw_q[62:52] == EXP_MAX);
    r0_nan = (r0_q[62:52] == EXP_MAX) && (r0_q[51:0] != 52'd0);

    state_d  = state_q;
    r0_d     = r0_q;
    r1_d     = r1_q;
    pw_d     = pw_q;
    k_d      = k_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    clear    = 1'b0;
    req      = '{start: 1'b0, op: OP_CVT};
    fa       = r0_q;
    fb       = pw_q;

    case (state_q)
      S_IDLE:  if (take && s_axis_tlast) state_d = S_CVTW;
      S_CVTW: begin
        req     = '{start: 1'b1, op: OP_CVT};
        fa      = {4'd0, whole};
        state_d = S_WCVTW;
      end
      S_WCVTW: if (fdone) begin
        r0_d    = fres;
        state_d = S_CVTF;
      end
      S_CVTF: begin
        req     = '{start: 1'b1, op: OP_CVT};
        fa      = {4'd0, frac};
        state_d = S_WCVTF;
      end
      S_WCVTF: if (fdone) begin
        r1_d    = fres;
        pw_d    = DBL_ONE;
        k_d     = K_W'(flen);
        state_d = S_POWF;
      end
      S_POWF: begin
        if (k_q == '0 || pw_inf) begin
          state_d = S_DIVF;
        end else begin
          req     = '{start: 1'b1, op: OP_MUL};
          fa      = pw_q;
          fb      = DBL_TEN;
          state_d = S_WPOWF;
        end
      end
      S_WPOWF: if (fdone) begin
        pw_d    = fres;
        k_d     = k_q - 1'b1;
        state_d = S_POWF;
      end
      S_DIVF: begin
        req     = '{start: 1'b1, op: OP_DIV};
        fa      = r1_q;
        state_d = S_WDIVF;
      end
      S_WDIVF: if (fdone) begin
        r1_d    = fres;
        state_d = S_ADD;
      end
      S_ADD: begin
        req     = '{start: 1'b1, op: OP_ADD};
        fb      = r1_q;
        state_d = S_WADD;
      end
      S_WADD: if (fdone) begin
        r0_d    = fres;
        pw_d    = DBL_ONE;
        k_d     = K_W'(expo);
        state_d = S_POWE;
      end
      S_POWE: begin
        if (k_q == '0 || pw_inf) begin
          state_d = S_SCALE;
        end else begin
          req     = '{start: 1'b1, op: OP_MUL};
          fa      = pw_q;
          fb      = DBL_TEN;
          state_d = S_WPOWE;
        end
      end
      S_WPOWE: if (fdone) begin
        pw_d    = fres;
        k_d     = k_q - 1'b1;
        state_d = S_POWE;
      end
      S_SCALE: begin
        req     = '{start: 1'b1, op: (eneg ? OP_DIV : OP_MUL)};
        state_d = S_WSCALE;
      end
      S_WSCALE: if (fdone) begin
        r0_d    = fres;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          // Negation leaves a NaN as it is and flips the sign of anything else.
          odata_d  = (mneg && !r0_nan) ? {~r0_q[63], r0_q[62:0]} : r0_q;
          ouser_d  = ovf;
          ovalid_d = 1'b1;
          clear    = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    pw_q    <= pw_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("request taken while a conversion runs");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fdone |-> (state_q == S_WCVTW || state_q == S_WCVTF || state_q == S_WPOWF ||
               state_q == S_WDIVF || state_q == S_WADD || state_q == S_WPOWE ||
               state_q == S_WSCALE))
    else $error("arithmetic unit finished outside a wait state");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result appeared without the output step");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the decimal text to double parser
// Streams number texts one character per request, with random gaps on the
// input and random stalls on the output. A scoreboard scans every accepted
// character in double arithmetic of its own and checks each returned double
// and overflow flag against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dttd_pkg::*;

  localparam logic [63:0] WHOLE_LIMIT = 64'd999999999999999999;
  localparam int          DIGIT_LIMIT = 18;
  localparam int          EXP_LIMIT   = 400;

  typedef struct {
    logic [63:0] value_bits;
    logic        overflow;
  } number_t;

  class number_scoreboard;
    number_t     pending[$];
    int          errors;
    int          numbers_done;
    mode_e       mode;
    bit          neg_mant;
    bit          neg_exp;
    bit          ovf;
    logic [63:0] whole;
    logic [63:0] frac;
    int          frac_len;
    int          expo;

    function void clear();
      mode = MODE_WHOLE;
      neg_mant = 0;
      neg_exp = 0;
      ovf = 0;
      whole = 0;
      frac = 0;
      frac_len = 0;
      expo = 0;
    endfunction

    function real power_of_ten(int k);
      real p;
      p = 1.0;
      for (int i = 0; i < k; i++) p = p * 10.0;
      return p;
    endfunction

    // Scans one accepted character; on the last one the double is queued.
    function void note_char(logic [7:0] c, bit last);
      bit          is_digit;
      logic [63:0] w;
      int          e;
      real         v;
      number_t     r;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (c != 8'h00) begin
        case (mode)
          MODE_FRAC: begin
            if (is_digit) begin
              if (frac_len >= DIGIT_LIMIT) ovf = 1;
              else begin
                frac = frac * 10 + (c - CH_ZERO);
                frac_len++;
              end
            end
            if (c == CH_LOW_E || c == CH_UP_E) mode = MODE_EXP;
          end
          MODE_EXP: begin
            if (c == CH_MINUS) neg_exp = 1;
            if (is_digit) begin
              e = expo * 10 + (c - CH_ZERO);
              if (e > EXP_LIMIT) begin
                e = EXP_LIMIT;
                ovf = 1;
              end
              expo = e;
            end
          end
          default: begin
            if (c == CH_MINUS) neg_mant = 1;
            if (is_digit) begin
              w = whole * 10 + (c - CH_ZERO);
              if (w > WHOLE_LIMIT) ovf = 1;
              else whole = w;
            end
            if (c == CH_DOT) mode = MODE_FRAC;
            if (c == CH_LOW_E || c == CH_UP_E) mode = MODE_EXP;
          end
        endcase
      end
      if (!last) return;
      v = real'(longint'(whole)) + real'(longint'(frac)) / power_of_ten(frac_len);
      if (neg_exp) v = v / power_of_ten(expo);
      else v = v * power_of_ten(expo);
      if (neg_mant) v = -1.0 * v;
      r.value_bits = $realtobits(v);
      // Zero times infinity gives the default quiet NaN of the hardware.
      if (r.value_bits[62:52] == EXP_MAX && r.value_bits[51:0] != 0) r.value_bits = DBL_NAN;
      r.overflow = ovf;
      pending.push_back(r);
      clear();
    endfunction

    function void check_number(logic [63:0] bits_got, logic ovf_got);
      number_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value %h overflow %b", $time, bits_got, ovf_got);
        errors++;
        return;
      end
      x = pending.pop_front();
      numbers_done++;
      if (bits_got !== x.value_bits) begin
        $display("%0t: value expected %h actual %h", $time, x.value_bits, bits_got);
        errors++;
      end
      if (ovf_got !== x.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, x.overflow, ovf_got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  number_scoreboard sb;
  int  chars_sent;
  bit  no_gaps;
  bit  no_stalls;

  always #2 clk_i = ~clk_i;

  decimal_text_to_double uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  task automatic send_char(logic [7:0] c, bit last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = c;
    s_axis_tlast = last;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.note_char(c, last);
    chars_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic append_digits(ref logic [7:0] t[$], input int n);
    for (int i = 0; i < n; i++) t.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Mostly well-formed numbers with random content, some noise and odd endings.
  task automatic send_random_number();
    logic [7:0] t[$];
    int n;
    no_gaps = ($urandom_range(0, 3) == 0);
    no_stalls = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 8);
      repeat (n) t.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) t.push_back(CH_MINUS);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 21) : $urandom_range(0, 6);
      append_digits(t, n);
      if ($urandom_range(0, 2) != 0) begin
        t.push_back(CH_DOT);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 21) : $urandom_range(0, 6);
        append_digits(t, n);
      end
      if ($urandom_range(0, 2) == 0) begin
        t.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
        if ($urandom_range(0, 1)) t.push_back(CH_MINUS);
        n = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(1, 2);
        append_digits(t, n);
      end
      if ($urandom_range(0, 7) == 0)
        t.insert($urandom_range(0, t.size()), 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) t.push_back(8'h00);
      if (t.size() == 0) t.push_back(CH_ZERO);
    end
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  // Result side: a random stall before each result, sometimes none.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready = 0;
      if (!no_stalls) repeat ($urandom_range(0, 13)) @(negedge clk_i);
      m_axis_tready = 1;
      forever begin
        @(posedge clk_i);
        if (m_axis_tvalid) break;
      end
      sb.check_number(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    #200ms;
    $display("decimal_text_to_double: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    send_text("0");
    send_text("-0");
    send_text("999999999999999999");
    send_text("1234567890123456789");
    send_text(".1234567890123456789");
    send_text("1e999");
    send_text("-2.5E-400");
    send_text("1.5e308");
    send_text("0e400");
    send_text("3.-1.4e-.2");
    send_char(CH_ZERO + 8'd7, 0);
    send_char(8'hFF, 0);
    send_char(8'h00, 1);
    send_char(8'h00, 1);

    while (chars_sent < 550) send_random_number();
    no_gaps = 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d characters; checked %0d numbers, including long digit runs,",
             chars_sent, sb.numbers_done);
    $display("saturated exponents, negative zero and ignored characters.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("decimal_text_to_double: match");
    end else begin
      $display("decimal_text_to_double: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
design/dttd_pkg.sv
design/dttd_scan.sv
design/dttd_fpu.sv
design/decimal_text_to_double.sv
tb/tb.sv
